>>> design/closest_point_on_triangle_2d_defines.svh
// Assertion macros shared by the closest-point block.
// Depends on nothing; files that check their own logic include it.
`ifndef CLOSEST_POINT_ON_TRIANGLE_2D_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_2D_DEFINES_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define CPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must be followed by a consequence in the next cycle.
`define CPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CPT_ASSERT(lbl, prop, msg)
`define CPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/cpt_pkg.sv
// Package for the closest-point-on-triangle block: defaults, region codes,
// queue sizing and the queue status type. Depends on nothing.
package cpt_pkg;
  localparam int CPT_COORD_WIDTH = 32;
  localparam int CPT_FRAC_BITS   = 16;

  localparam logic [2:0] REGION_INSIDE = 3'd0;
  localparam logic [2:0] REGION_A      = 3'd1;
  localparam logic [2:0] REGION_B      = 3'd2;
  localparam logic [2:0] REGION_C      = 3'd3;
  localparam logic [2:0] REGION_AB     = 3'd4;
  localparam logic [2:0] REGION_BC     = 3'd5;
  localparam logic [2:0] REGION_CA     = 3'd6;

  localparam int CPT_QDEPTH = 8;
  localparam int CPT_QPTR_W = $clog2(CPT_QDEPTH);
  localparam int CPT_QCNT_W = $clog2(CPT_QDEPTH + 1);

  typedef struct packed {
    logic                  empty;
    logic [CPT_QCNT_W-1:0] count;
  } cpt_q_stat_t;
endpackage

>>> design/cpt_fifo.sv
// Short register queue between the classifier and the projection pipeline.
// Depends on cpt_pkg and the assertion macro header.
`include "closest_point_on_triangle_2d_defines.svh"
module cpt_fifo import cpt_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output cpt_q_stat_t      stat
);
  logic [WIDTH-1:0]      mem_r [0:CPT_QDEPTH-1];
  logic [CPT_QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CPT_QCNT_W-1:0] count_r, count_nxt;
  logic                  do_pop;

  assign do_pop   = pop && (count_r != '0);
  assign wptr_nxt = push ? CPT_QPTR_W'(wptr_r + 1'b1) : wptr_r;
  assign rptr_nxt = do_pop ? CPT_QPTR_W'(rptr_r + 1'b1) : rptr_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = CPT_QCNT_W'(count_r + 1'b1);
    end else if (!push && do_pop) begin
      count_nxt = CPT_QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  assign pop_data    = mem_r[rptr_r];
  assign stat.empty  = (count_r == '0);
  assign stat.count  = count_r;

  `CPT_ASSERT(a_no_overflow, !(push && !do_pop && count_r == CPT_QCNT_W'(CPT_QDEPTH)), "queue overflow")
  `CPT_ASSERT(a_ptr_gap, (CPT_QPTR_W'(wptr_r - rptr_r) == CPT_QPTR_W'(count_r)), "pointer mismatch")
  `CPT_ASSERT_NEXT(a_push_grows, push && !do_pop, count_r == CPT_QCNT_W'($past(count_r) + 1'b1), "count did not grow")
endmodule

>>> design/cpt_front.sv
// Front end: edge differences, cross products, region choice and the
// edge (start, direction, offset) handed to the queue. Depends on cpt_pkg.
module cpt_front import cpt_pkg::*; #(
  parameter int COORD_WIDTH = CPT_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [COORD_WIDTH-1:0] a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y,
  output logic [1:0]                    inflight,
  output logic                          push,
  output logic [3+2*COORD_WIDTH+4*(COORD_WIDTH+1)-1:0] push_data
);
  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  logic signed [DW-1:0] abx_c, aby_c, bcx_c, bcy_c, cax_c, cay_c;
  logic signed [DW-1:0] apx_c, apy_c, bpx_c, bpy_c, cpx_c, cpy_c;

  assign abx_c = $signed({b_x[W-1], b_x}) - $signed({a_x[W-1], a_x});
  assign aby_c = $signed({b_y[W-1], b_y}) - $signed({a_y[W-1], a_y});
  assign bcx_c = $signed({c_x[W-1], c_x}) - $signed({b_x[W-1], b_x});
  assign bcy_c = $signed({c_y[W-1], c_y}) - $signed({b_y[W-1], b_y});
  assign cax_c = $signed({a_x[W-1], a_x}) - $signed({c_x[W-1], c_x});
  assign cay_c = $signed({a_y[W-1], a_y}) - $signed({c_y[W-1], c_y});
  assign apx_c = $signed({p_x[W-1], p_x}) - $signed({a_x[W-1], a_x});
  assign apy_c = $signed({p_y[W-1], p_y}) - $signed({a_y[W-1], a_y});
  assign bpx_c = $signed({p_x[W-1], p_x}) - $signed({b_x[W-1], b_x});
  assign bpy_c = $signed({p_y[W-1], p_y}) - $signed({b_y[W-1], b_y});
  assign cpx_c = $signed({p_x[W-1], p_x}) - $signed({c_x[W-1], c_x});
  assign cpy_c = $signed({p_y[W-1], p_y}) - $signed({c_y[W-1], c_y});

  // Stage 1: coordinates and differences.
  logic                 v1_r;
  logic signed [W-1:0]  ax1_r, ay1_r, bx1_r, by1_r, cx1_r, cy1_r, px1_r, py1_r;
  logic signed [DW-1:0] abx1_r, aby1_r, bcx1_r, bcy1_r, cax1_r, cay1_r;
  logic signed [DW-1:0] apx1_r, apy1_r, bpx1_r, bpy1_r, cpx1_r, cpy1_r;

  // Stage 2: cross product terms.
  logic                 v2_r;
  logic signed [W-1:0]  ax2_r, ay2_r, bx2_r, by2_r, cx2_r, cy2_r, px2_r, py2_r;
  logic signed [DW-1:0] abx2_r, aby2_r, bcx2_r, bcy2_r, cax2_r, cay2_r;
  logic signed [DW-1:0] apx2_r, apy2_r, bpx2_r, bpy2_r, cpx2_r, cpy2_r;
  logic signed [PW-1:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax1_r <= a_x; ay1_r <= a_y; bx1_r <= b_x; by1_r <= b_y;
      cx1_r <= c_x; cy1_r <= c_y; px1_r <= p_x; py1_r <= p_y;
      abx1_r <= abx_c; aby1_r <= aby_c; bcx1_r <= bcx_c; bcy1_r <= bcy_c;
      cax1_r <= cax_c; cay1_r <= cay_c; apx1_r <= apx_c; apy1_r <= apy_c;
      bpx1_r <= bpx_c; bpy1_r <= bpy_c; cpx1_r <= cpx_c; cpy1_r <= cpy_c;
    end
    if (v1_r) begin
      ax2_r <= ax1_r; ay2_r <= ay1_r; bx2_r <= bx1_r; by2_r <= by1_r;
      cx2_r <= cx1_r; cy2_r <= cy1_r; px2_r <= px1_r; py2_r <= py1_r;
      abx2_r <= abx1_r; aby2_r <= aby1_r; bcx2_r <= bcx1_r; bcy2_r <= bcy1_r;
      cax2_r <= cax1_r; cay2_r <= cay1_r; apx2_r <= apx1_r; apy2_r <= apy1_r;
      bpx2_r <= bpx1_r; bpy2_r <= bpy1_r; cpx2_r <= cpx1_r; cpy2_r <= cpy1_r;
      m0_r <= abx1_r * apy1_r;
      m1_r <= aby1_r * apx1_r;
      m2_r <= bcx1_r * bpy1_r;
      m3_r <= bcy1_r * bpx1_r;
      m4_r <= cax1_r * cpy1_r;
      m5_r <= cay1_r * cpx1_r;
    end
  end

  logic signed [CW-1:0] xab, xbc, xca;
  logic                 nab, nbc, nca;
  logic [2:0]           region;
  logic signed [W-1:0]  sx, sy;
  logic signed [DW-1:0] dx, dy, wx, wy;

  assign xab = $signed({m0_r[PW-1], m0_r}) - $signed({m1_r[PW-1], m1_r});
  assign xbc = $signed({m2_r[PW-1], m2_r}) - $signed({m3_r[PW-1], m3_r});
  assign xca = $signed({m4_r[PW-1], m4_r}) - $signed({m5_r[PW-1], m5_r});
  assign nab = xab[CW-1];
  assign nbc = xbc[CW-1];
  assign nca = xca[CW-1];

  // Vertex and inside cases carry a zero edge, which the back end turns
  // into the start point unchanged.
  always_comb begin
    region = REGION_INSIDE;
    sx = px2_r; sy = py2_r;
    dx = '0; dy = '0; wx = '0; wy = '0;
    if (nab && !nbc && nca) begin
      region = REGION_A; sx = ax2_r; sy = ay2_r;
    end else if (nab && nbc && !nca) begin
      region = REGION_B; sx = bx2_r; sy = by2_r;
    end else if (!nab && nbc && nca) begin
      region = REGION_C; sx = cx2_r; sy = cy2_r;
    end else if (nab && !nbc && !nca) begin
      region = REGION_AB; sx = ax2_r; sy = ay2_r;
      dx = abx2_r; dy = aby2_r; wx = apx2_r; wy = apy2_r;
    end else if (!nab && nbc && !nca) begin
      region = REGION_BC; sx = bx2_r; sy = by2_r;
      dx = bcx2_r; dy = bcy2_r; wx = bpx2_r; wy = bpy2_r;
    end else if (!nab && !nbc && nca) begin
      region = REGION_CA; sx = cx2_r; sy = cy2_r;
      dx = cax2_r; dy = cay2_r; wx = cpx2_r; wy = cpy2_r;
    end
  end

  assign push      = v2_r;
  assign push_data = {region, sx, sy, dx, dy, wx, wy};
  assign inflight  = {1'b0, v1_r} + {1'b0, v2_r};
endmodule

>>> design/cpt_back.sv
// Back end: dot product and squared length, a pipelined restoring divider
// for t, and the scaled offset added to the edge start. Depends on cpt_pkg.
module cpt_back import cpt_pkg::*; #(
  parameter int COORD_WIDTH = CPT_COORD_WIDTH,
  parameter int FRAC_BITS   = CPT_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [3+2*COORD_WIDTH+4*(COORD_WIDTH+1)-1:0] item,
  output logic                          res_valid,
  output logic signed [COORD_WIDTH-1:0] res_x,
  output logic signed [COORD_WIDTH-1:0] res_y,
  output logic [2:0]                    res_region
);
  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;
  localparam int MW = F + 2 + DW;

  logic [2:0]           i_region;
  logic signed [W-1:0]  i_sx, i_sy;
  logic signed [DW-1:0] i_dx, i_dy, i_wx, i_wy;
  assign {i_region, i_sx, i_sy, i_dx, i_dy, i_wx, i_wy} = item;

  // Stage 1: the four products.
  logic                 v1_r;
  logic [2:0]           rg1_r;
  logic signed [W-1:0]  sx1_r, sy1_r;
  logic signed [DW-1:0] dx1_r, dy1_r;
  logic signed [PW-1:0] pxw_r, pyw_r, pxx_r, pyy_r;
  // Stage 2: dot and squared length.
  logic                 v2_r;
  logic [2:0]           rg2_r;
  logic signed [W-1:0]  sx2_r, sy2_r;
  logic signed [DW-1:0] dx2_r, dy2_r;
  logic signed [CW-1:0] dot2_r;
  logic [CW-1:0]        len2_r;

  always_ff @(posedge clk) begin
    if (take) begin
      rg1_r <= i_region; sx1_r <= i_sx; sy1_r <= i_sy; dx1_r <= i_dx; dy1_r <= i_dy;
      pxw_r <= i_dx * i_wx;
      pyw_r <= i_dy * i_wy;
      pxx_r <= i_dx * i_dx;
      pyy_r <= i_dy * i_dy;
    end
    if (v1_r) begin
      rg2_r <= rg1_r; sx2_r <= sx1_r; sy2_r <= sy1_r; dx2_r <= dx1_r; dy2_r <= dy1_r;
      dot2_r <= $signed({pxw_r[PW-1], pxw_r}) + $signed({pyw_r[PW-1], pyw_r});
      len2_r <= {1'b0, pxx_r} + {1'b0, pyy_r};
    end
  end

  // Divider pipeline, stage 0 loaded from the case decision.
  logic                 dv_r  [0:F];
  logic [2:0]           drg_r [0:F];
  logic signed [W-1:0]  dsx_r [0:F];
  logic signed [W-1:0]  dsy_r [0:F];
  logic signed [DW-1:0] ddx_r [0:F];
  logic signed [DW-1:0] ddy_r [0:F];
  logic [CW-1:0]        rem_r [0:F];
  logic [CW-1:0]        dl_r  [0:F];
  logic [F-1:0]         q_r   [0:F];
  logic                 sp_r  [0:F];
  logic                 spt_r [0:F];

  logic dot_le0, is_sp, sp_one;
  assign dot_le0 = dot2_r[CW-1] || (dot2_r == '0);
  assign is_sp   = (len2_r == '0) || dot_le0 || ($unsigned(dot2_r) >= len2_r);
  assign sp_one  = (len2_r == '0) || !dot_le0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      dv_r[0]  <= 1'b0;
    end else begin
      v1_r     <= take;
      v2_r     <= v1_r;
      dv_r[0]  <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      drg_r[0] <= rg2_r; dsx_r[0] <= sx2_r; dsy_r[0] <= sy2_r;
      ddx_r[0] <= dx2_r; ddy_r[0] <= dy2_r;
      rem_r[0] <= $unsigned(dot2_r);
      dl_r[0]  <= len2_r;
      q_r[0]   <= '0;
      sp_r[0]  <= is_sp;
      spt_r[0] <= sp_one;
    end
  end

  for (genvar k = 0; k < F; k++) begin : g_div
    logic [CW:0] rem2, diff;
    logic        ge;
    assign rem2 = {rem_r[k], 1'b0};
    assign ge   = (rem2 >= {1'b0, dl_r[k]});
    assign diff = rem2 - {1'b0, dl_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (dv_r[k]) begin
        drg_r[k+1] <= drg_r[k]; dsx_r[k+1] <= dsx_r[k]; dsy_r[k+1] <= dsy_r[k];
        ddx_r[k+1] <= ddx_r[k]; ddy_r[k+1] <= ddy_r[k];
        dl_r[k+1]  <= dl_r[k];
        sp_r[k+1]  <= sp_r[k];
        spt_r[k+1] <= spt_r[k];
        rem_r[k+1] <= ge ? diff[CW-1:0] : rem2[CW-1:0];
        q_r[k+1]   <= {q_r[k][F-2:0], ge};
      end
    end
  end

  // Offset multiply, then add to the start point.
  logic [F:0]           t_c;
  logic                 vm_r;
  logic [2:0]           rgm_r;
  logic signed [W-1:0]  sxm_r, sym_r;
  logic signed [MW-1:0] ox_r, oy_r;

  always_comb begin
    if (sp_r[F]) begin
      t_c = spt_r[F] ? {1'b1, {F{1'b0}}} : '0;
    end else begin
      t_c = {1'b0, q_r[F]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      vm_r      <= dv_r[F];
      res_valid <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_r[F]) begin
      rgm_r <= drg_r[F]; sxm_r <= dsx_r[F]; sym_r <= dsy_r[F];
      ox_r  <= $signed({1'b0, t_c}) * ddx_r[F];
      oy_r  <= $signed({1'b0, t_c}) * ddy_r[F];
    end
    if (vm_r) begin
      res_region <= rgm_r;
      res_x      <= sxm_r + $signed(ox_r[F+W-1:F]);
      res_y      <= sym_r + $signed(oy_r[F+W-1:F]);
    end
  end
endmodule

>>> design/closest_point_on_triangle_2d.sv
// Top level of the closest-point-on-triangle block.
// Depends on cpt_pkg, cpt_front, cpt_fifo and cpt_back.
//
// Each transfer brings triangle vertices A, B, C (counter-clockwise) and a
// query point P in signed fixed point, and yields one result: the point of
// the triangle closest to P and a region code (inside, a vertex, or an edge).
// Results appear on the out_ ports for exactly one cycle with out_valid high,
// in the order the items came in; the receiver cannot hold them off. A new
// item may be started every clock cycle while busy is low. The front end
// (two stages: edge differences, then cross products and region choice)
// writes into an eight-entry queue, and the back end drains it every cycle
// when it is not empty. An item then passes through two back-end product
// stages, the divider load, the pipelined restoring divider, which resolves
// one bit of t in each of its FRAC_BITS stages, the offset multiply and the
// final add. busy rises only when the queue plus the items inside the front
// end would reach the queue depth, which does not happen in normal streaming
// because the back end never stalls. Zero-length edges give t = 1; a
// clockwise triangle with all three cross products negative reports inside
// and returns P.
module closest_point_on_triangle_2d import cpt_pkg::*; #(
  parameter int COORD_WIDTH = CPT_COORD_WIDTH,
  parameter int FRAC_BITS   = CPT_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_vert_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_vert_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_query_x,
  input  logic signed [COORD_WIDTH-1:0] in_query_y,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_closest_x,
  output logic signed [COORD_WIDTH-1:0] out_closest_y,
  output logic [2:0]                    out_region
);
  // Queue entry: region, start point, edge vector and point offset.
  localparam int IW = 3 + 2 * COORD_WIDTH + 4 * (COORD_WIDTH + 1);

  logic          accept;
  logic [1:0]    inflight;
  logic          push;
  logic [IW-1:0] push_data, pop_data;
  cpt_q_stat_t   q_stat;
  logic [CPT_QCNT_W:0] occupancy;

  assign accept = start && !busy;

  // Reserve a queue slot for every item still in the front end.
  assign occupancy = (CPT_QCNT_W+1)'(q_stat.count) + (CPT_QCNT_W+1)'(inflight);
  assign busy      = (occupancy >= (CPT_QCNT_W+1)'(CPT_QDEPTH));

  cpt_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .a_x      (in_vert_a_x),
    .a_y      (in_vert_a_y),
    .b_x      (in_vert_b_x),
    .b_y      (in_vert_b_y),
    .c_x      (in_vert_c_x),
    .c_y      (in_vert_c_y),
    .p_x      (in_query_x),
    .p_y      (in_query_y),
    .inflight (inflight),
    .push     (push),
    .push_data(push_data)
  );

  cpt_fifo #(
    .WIDTH(IW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (!q_stat.empty),
    .pop_data (pop_data),
    .stat     (q_stat)
  );

  cpt_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (!q_stat.empty),
    .item      (pop_data),
    .res_valid (out_valid),
    .res_x     (out_closest_x),
    .res_y     (out_closest_y),
    .res_region(out_region)
  );
endmodule

>>> verif/tb_closest_point_on_triangle_2d.sv
// Testbench for closest_point_on_triangle_2d: directed and random triangles and
// query points, each result checked against a built-in predictor. Depends on cpt_pkg.
`timescale 1ns / 1ps

module tb_closest_point_on_triangle_2d;
  import cpt_pkg::*;

  localparam int CW = CPT_COORD_WIDTH;
  localparam int FB = CPT_FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t ax, ay, bx, by, cx, cy, px, py;
  } tri_query_t;

  typedef struct {
    coord_t cx, cy;
    logic [2:0] region;
  } closest_t;

  logic clk, rst_n, start, busy;
  coord_t in_vert_a_x, in_vert_a_y, in_vert_b_x, in_vert_b_y;
  coord_t in_vert_c_x, in_vert_c_y, in_query_x, in_query_y;
  logic out_valid;
  coord_t out_closest_x, out_closest_y;
  logic [2:0] out_region;

  closest_t expected_points[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 0;

  closest_point_on_triangle_2d dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vert_a_x(in_vert_a_x), .in_vert_a_y(in_vert_a_y),
    .in_vert_b_x(in_vert_b_x), .in_vert_b_y(in_vert_b_y),
    .in_vert_c_x(in_vert_c_x), .in_vert_c_y(in_vert_c_y),
    .in_query_x(in_query_x), .in_query_y(in_query_y),
    .out_valid(out_valid), .out_closest_x(out_closest_x),
    .out_closest_y(out_closest_y), .out_region(out_region)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Projects P onto the edge from S along D; w is P - S. All products are kept
  // at 128 bits so that nothing wraps, as the block computes them exactly.
  function automatic void project_edge(input logic signed [63:0] sx, sy, dx, dy, wx, wy,
                                       output coord_t ox, output coord_t oy);
    logic signed [127:0] dot, len2, ox_full, oy_full;
    logic [FB:0] t;
    dot  = dx * wx + dy * wy;
    len2 = dx * dx + dy * dy;
    if (len2 == 0) t = 1 << FB;
    else if (dot <= 0) t = 0;
    else if (dot >= len2) t = 1 << FB;
    else t = (dot <<< FB) / len2;
    // Arithmetic shift floors toward minus infinity.
    ox_full = sx + ((128'(signed'({1'b0, t})) * dx) >>> FB);
    oy_full = sy + ((128'(signed'({1'b0, t})) * dy) >>> FB);
    ox = ox_full[CW-1:0];
    oy = oy_full[CW-1:0];
  endfunction

  function automatic closest_t predict_closest(input tri_query_t q);
    closest_t r;
    logic signed [63:0] ax, ay, bx, by, cx, cy, px, py;
    logic signed [127:0] abx, bcx, cax;
    bit nab, nbc, nca;
    ax = q.ax; ay = q.ay; bx = q.bx; by = q.by;
    cx = q.cx; cy = q.cy; px = q.px; py = q.py;
    abx = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    bcx = (cx - bx) * (py - by) - (cy - by) * (px - bx);
    cax = (ax - cx) * (py - cy) - (ay - cy) * (px - cx);
    nab = abx < 0; nbc = bcx < 0; nca = cax < 0;
    r.cx = q.px; r.cy = q.py; r.region = REGION_INSIDE;
    if (nab && !nbc && nca) begin
      r.cx = q.ax; r.cy = q.ay; r.region = REGION_A;
    end else if (nab && nbc && !nca) begin
      r.cx = q.bx; r.cy = q.by; r.region = REGION_B;
    end else if (!nab && nbc && nca) begin
      r.cx = q.cx; r.cy = q.cy; r.region = REGION_C;
    end else if (nab && !nbc && !nca) begin
      project_edge(ax, ay, bx - ax, by - ay, px - ax, py - ay, r.cx, r.cy);
      r.region = REGION_AB;
    end else if (!nab && nbc && !nca) begin
      project_edge(bx, by, cx - bx, cy - by, px - bx, py - by, r.cx, r.cy);
      r.region = REGION_BC;
    end else if (!nab && !nbc && nca) begin
      project_edge(cx, cy, ax - cx, ay - cy, px - cx, py - cy, r.cx, r.cy);
      r.region = REGION_CA;
    end
    return r;
  endfunction

  // Sender gap: most transfers go back to back; some bursts start after an idle wait.
  int burst_left = 0;

  task automatic send_query(input tri_query_t q);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (start) begin
        start <= 1'b0;
        @(posedge clk);
        if (gap > 0) gap--;
      end
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    start <= 1'b1;
    in_vert_a_x <= q.ax; in_vert_a_y <= q.ay;
    in_vert_b_x <= q.bx; in_vert_b_y <= q.by;
    in_vert_c_x <= q.cx; in_vert_c_y <= q.cy;
    in_query_x <= q.px; in_query_y <= q.py;
    // The transfer happens at the first edge with busy low.
    do @(posedge clk); while (busy);
    expected_points.push_back(predict_closest(q));
  endtask

  // Checks every strobed result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      closest_t e;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h region=%0d", $time,
                 out_closest_x, out_closest_y, out_region);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (out_closest_x !== e.cx) begin
          $display("%0t: closest_x expected %h actual %h", $time, e.cx, out_closest_x);
          errors++;
        end
        if (out_closest_y !== e.cy) begin
          $display("%0t: closest_y expected %h actual %h", $time, e.cy, out_closest_y);
          errors++;
        end
        if (out_region !== e.region) begin
          $display("%0t: region expected %0d actual %0d", $time, e.region, out_region);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no transfer in either direction.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles = 0;
    else if (!stim_done || expected_points.size() != 0) idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
      2: return coord_t'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
      default: return coord_t'($signed($urandom_range(0, 16)) - 8) <<< FB;
    endcase
  endfunction

  // A counter-clockwise triangle with a query anywhere near it.
  function automatic tri_query_t rand_ccw_query(input int mode);
    tri_query_t q;
    logic signed [127:0] area;
    q.ax = rand_coord(mode); q.ay = rand_coord(mode);
    q.bx = rand_coord(mode); q.by = rand_coord(mode);
    q.cx = rand_coord(mode); q.cy = rand_coord(mode);
    area = (128'(q.bx) - q.ax) * (128'(q.cy) - q.ay) - (128'(q.by) - q.ay) * (128'(q.cx) - q.ax);
    if (area < 0) begin
      coord_t tx, ty;
      tx = q.bx; ty = q.by; q.bx = q.cx; q.by = q.cy; q.cx = tx; q.cy = ty;
    end
    q.px = rand_coord(mode); q.py = rand_coord(mode);
    return q;
  endfunction

  function automatic tri_query_t make_query(input coord_t ax, ay, bx, by, cx, cy, px, py);
    tri_query_t q;
    q.ax = ax; q.ay = ay; q.bx = bx; q.by = by;
    q.cx = cx; q.cy = cy; q.px = px; q.py = py;
    return q;
  endfunction

  // Unit triangle A(0,0), B(4,0), C(0,4) with queries in every region.
  task automatic test_regions();
    coord_t u;
    u = 32'sh0001_0000;
    send_query(make_query(0, 0, 4*u, 0, 0, 4*u, u, u));          // inside
    send_query(make_query(0, 0, 4*u, 0, 0, 4*u, -u, -u));        // vertex A
    send_query(make_query(0, 0, 4*u, 0, 0, 4*u, 6*u, -u));       // vertex B
    send_query(make_query(0, 0, 4*u, 0, 0, 4*u, -u, 6*u));       // vertex C
    send_query(make_query(0, 0, 4*u, 0, 0, 4*u, u + 7, -u));     // edge AB
    send_query(make_query(0, 0, 4*u, 0, 0, 4*u, 3*u, 3*u + 5));  // edge BC
    send_query(make_query(0, 0, 4*u, 0, 0, 4*u, -u, 3*u + 1));   // edge CA
    send_query(make_query(0, 0, 4*u, 0, 0, 4*u, 2*u, 0));        // on an edge
  endtask

  // Zero-length edges, clamping of t at both ends, a clockwise triangle and
  // coordinates at the extremes of the signed range.
  task automatic test_special_cases();
    coord_t mx, mn, u;
    mx = 32'sh7FFF_FFFF; mn = 32'sh8000_0000; u = 32'sh0001_0000;
    send_query(make_query(u, u, u, u, u, u, 5*u, -3*u));          // fully degenerate
    send_query(make_query(0, 0, 0, 0, 0, 4*u, u, -u));            // zero-length AB
    send_query(make_query(0, 0, 4*u, 0, 4*u, 0, 9*u, 9*u));       // zero-length BC
    send_query(make_query(0, 0, 0, 4*u, 4*u, 0, u, u));           // clockwise
    send_query(make_query(0, 0, 4*u, 0, 0, 4*u, 0, -u));          // t clamps to zero
    send_query(make_query(0, 0, 4*u, 0, 0, 4*u, 4*u, -u));        // t at one
    send_query(make_query(mn, mn, mx, mn, mn, mx, mx, mx));
    send_query(make_query(mn, mn, mx, mn, mn, mx, 0, mn));
    send_query(make_query(mn, mn, mx, mn, mn, mx, mn, mn));
    send_query(make_query(mx, mx, mn, mx, mx, mn, mn, mn));
    send_query(make_query(-1, -1, mx, mn, mn, mx, mx, mn + 1));
    send_query(make_query(mn, 0, mx, 0, 0, mx, 0, mn));
    send_query(make_query(mx, mx, mx, mx, mx, mx, mn, mn));
  endtask

  // Mostly well-formed counter-clockwise triangles; the rest raw noise.
  task automatic test_random(input int count);
    tri_query_t q;
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) begin
        q = make_query(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                       coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                       coord_t'($urandom), coord_t'($urandom));
      end else begin
        q = rand_ccw_query(mode);
      end
      send_query(q);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_vert_a_x = 0; in_vert_a_y = 0; in_vert_b_x = 0; in_vert_b_y = 0;
    in_vert_c_x = 0; in_vert_c_y = 0; in_query_x = 0; in_query_y = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_regions();
    test_special_cases();
    test_random(1530);
    start <= 1'b0;
    stim_done = 1;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (FB + 16) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+design
design/cpt_pkg.sv
design/cpt_fifo.sv
design/cpt_front.sv
design/cpt_back.sv
design/closest_point_on_triangle_2d.sv
verif/tb_closest_point_on_triangle_2d.sv
